>>> hw/rtl/cursor_ring_list_core_macros.svh
// Assertion macros shared by the checker of the cursor ring list core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef CURSOR_RING_LIST_CORE_MACROS_SVH
`define CURSOR_RING_LIST_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CRL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CRL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/crl_pkg.sv
// Package for the cursor ring list core: request and result structs, codes and FSM states.
// No dependencies; used by the core, its checker and the testbench.
`timescale 1ns / 1ps

package crl_pkg;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_FORWARD = 3'd2;
  localparam logic [2:0] REQ_BACK    = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] entry_data;
  } in_req_t;

  typedef struct packed {
    logic [15:0] current_data;
    logic        current_valid;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK,
    S_FETCH
  } state_t;

endpackage

>>> hw/rtl/cursor_ring_list_core.sv
// Cursor ring list core: a bounded doubly linked ring of entries with a cursor.
// Depends on crl_pkg for the request/result structs, codes and FSM states.
`timescale 1ns / 1ps

// Channel   Ports                          Handshake
// request   start, busy, in_req            taken when start is high and busy is low
// result    out_valid, out_rsp             one-cycle strobe, cannot be held off
//
// The result strobe follows the EXEC, LINK and FETCH states of an accepted request, and
// the next request may be taken at the edge that ends the strobe cycle, so a new request
// is taken only after the result of the last one. The state sequence is set by the
// single write port of the link memories (an insert rewrites two next and two previous
// links) and by the registered read of the payload at the new cursor.
// Reset empties the list: slots are handed out by a high-water mark and a stack of
// freed slots, so no memory needs clearing.

module cursor_ring_list_core #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  crl_pkg::in_req_t  in_req,
  output logic              out_valid,
  output crl_pkg::out_rsp_t out_rsp
);

  import crl_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Link, payload and free-slot memories.
  logic [AW-1:0]         next_mem [CAPACITY];
  logic [AW-1:0]         prev_mem [CAPACITY];
  logic [DATA_WIDTH-1:0] data_mem [CAPACITY];
  logic [AW-1:0]         free_mem [CAPACITY];

  logic [AW-1:0]         next_rd_r;
  logic [AW-1:0]         prev_rd_r;
  logic [DATA_WIDTH-1:0] data_rd_r;
  logic [AW-1:0]         free_rd_r;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         cursor_r, cursor_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         ftop_r, ftop_nxt;
  logic [CW-1:0]         hwm_r, hwm_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic [2:0]            req_r;
  logic [15:0]           din_r;
  logic [1:0]            status_r, status_nxt;
  logic [AW-1:0]         after_r, after_nxt;
  logic [AW-1:0]         oldc_r, oldc_nxt;
  logic                  link2_r, link2_nxt;
  out_rsp_t              rsp_r, rsp_nxt;

  logic                  next_we;
  logic [AW-1:0]         next_wa, next_wd;
  logic                  prev_we;
  logic [AW-1:0]         prev_wa, prev_wd;
  logic                  data_we;
  logic [AW-1:0]         data_wa;
  logic                  free_we;
  logic [AW-1:0]         free_wa, free_wd;

  logic [AW-1:0]         slot;
  logic [AW-1:0]         free_ra;
  logic [CW-1:0]         ftop_dec;
  logic [DATA_WIDTH+15:0] din_ext;
  logic [DATA_WIDTH+15:0] dout_ext;
  logic [CW+6:0]         count_ext;
  logic [DATA_WIDTH-1:0] data_wd;

  assign ftop_dec  = ftop_r - CW'(1);
  assign free_ra   = ftop_dec[AW-1:0];
  // A freed slot is reused first; otherwise the next never-used slot is taken.
  assign slot      = (ftop_r != '0) ? free_rd_r : hwm_r[AW-1:0];
  assign din_ext   = {{DATA_WIDTH{1'b0}}, din_r};
  assign data_wd   = din_ext[DATA_WIDTH-1:0];
  assign dout_ext  = {16'b0, data_rd_r};
  assign count_ext = {7'b0, count_nxt};

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (data_we) begin
      data_mem[data_wa] <= data_wd;
    end
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    next_rd_r <= next_mem[cursor_r];
    prev_rd_r <= prev_mem[cursor_r];
    data_rd_r <= data_mem[cursor_r];
    free_rd_r <= free_mem[free_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      count_r     <= '0;
      ftop_r      <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
      link2_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      count_r     <= count_nxt;
      ftop_r      <= ftop_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
      link2_r     <= link2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      req_r <= in_req.req_type;
      din_r <= in_req.entry_data;
    end
    status_r <= status_nxt;
    after_r  <= after_nxt;
    oldc_r   <= oldc_nxt;
    rsp_r    <= rsp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    count_nxt     = count_r;
    ftop_nxt      = ftop_r;
    hwm_nxt       = hwm_r;
    out_valid_nxt = 1'b0;
    link2_nxt     = link2_r;
    status_nxt    = status_r;
    after_nxt     = after_r;
    oldc_nxt      = oldc_r;
    rsp_nxt       = rsp_r;
    next_we       = 1'b0;
    next_wa       = slot;
    next_wd       = slot;
    prev_we       = 1'b0;
    prev_wa       = slot;
    prev_wd       = slot;
    data_we       = 1'b0;
    data_wa       = slot;
    free_we       = 1'b0;
    free_wa       = ftop_r[AW-1:0];
    free_wd       = cursor_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt  = S_LINK;
        status_nxt = ST_DONE;
        link2_nxt  = 1'b0;
        after_nxt  = next_rd_r;
        oldc_nxt   = cursor_r;
        unique case (req_r)
          REQ_INSERT: begin
            if (count_r == CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
            end else begin
              data_we    = 1'b1;
              next_we    = 1'b1;
              prev_we    = 1'b1;
              if (count_r != '0) begin
                // New slot sits between the cursor and its successor; the two
                // neighbor links are patched in the following cycle.
                next_wd   = next_rd_r;
                prev_wd   = cursor_r;
                link2_nxt = 1'b1;
              end
              if (ftop_r != '0) begin
                ftop_nxt = ftop_dec;
              end else begin
                hwm_nxt = hwm_r + CW'(1);
              end
              cursor_nxt = slot;
              count_nxt  = count_r + CW'(1);
            end
          end
          REQ_REMOVE: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              free_we    = 1'b1;
              ftop_nxt   = ftop_r + CW'(1);
              count_nxt  = count_r - CW'(1);
              if (count_r == CW'(1)) begin
                cursor_nxt = '0;
              end else begin
                next_we    = 1'b1;
                next_wa    = prev_rd_r;
                next_wd    = next_rd_r;
                prev_we    = 1'b1;
                prev_wa    = next_rd_r;
                prev_wd    = prev_rd_r;
                cursor_nxt = next_rd_r;
              end
            end
          end
          REQ_FORWARD: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cursor_nxt = next_rd_r;
            end
          end
          REQ_BACK: begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              cursor_nxt = prev_rd_r;
            end
          end
          default: begin
            // Read only, and the unused codes behave the same way.
          end
        endcase
      end

      S_LINK: begin
        state_nxt = S_FETCH;
        if (link2_r) begin
          prev_we = 1'b1;
          prev_wa = after_r;
          prev_wd = cursor_r;
          next_we = 1'b1;
          next_wa = oldc_r;
          next_wd = cursor_r;
        end
      end

      S_FETCH: begin
        state_nxt                 = S_IDLE;
        out_valid_nxt             = 1'b1;
        rsp_nxt.current_data      = (count_r != '0) ? dout_ext[15:0] : 16'd0;
        rsp_nxt.current_valid     = (count_r != '0);
        rsp_nxt.entry_count       = count_ext[6:0];
        rsp_nxt.status            = status_r;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/crl_checker.sv
// Port-level checker for the cursor ring list core, attached by a bind statement.
// Depends on crl_pkg and on the assertion macros in cursor_ring_list_core_macros.svh.
`timescale 1ns / 1ps
`include "cursor_ring_list_core_macros.svh"

module crl_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input crl_pkg::out_rsp_t out_rsp
);

  import crl_pkg::*;

  // An accepted request keeps the core busy until its result is shown.
  `CRL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `CRL_ASSERT_SAME(a_done_strobe, $fell(busy), out_valid, "busy dropped without a result")
  `CRL_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `CRL_ASSERT_SAME(a_valid_count, out_valid,
                   out_rsp.current_valid == (out_rsp.entry_count != 7'd0),
                   "current_valid disagrees with the entry count")
  `CRL_ASSERT_SAME(a_empty_data, out_valid && !out_rsp.current_valid,
                   out_rsp.current_data == 16'd0 && out_rsp.status != ST_FULL,
                   "empty list reported data or a full status")

endmodule

bind cursor_ring_list_core crl_checker u_crl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

>>> tb/cursor_ring_list_core_test.sv
// Self-checking testbench for cursor_ring_list_core: directed and phased random requests.
// Depends on crl_pkg for the request/result structs and the request and status codes.
`timescale 1ns / 1ps

module cursor_ring_list_core_test;
  import crl_pkg::*;

  localparam int LIST_CAPACITY = 64;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    MIX_FILL,
    MIX_MIXED,
    MIX_DRAIN
  } request_mix_t;

  // Predicts the ring as an ordered queue of payloads plus a cursor position.
  // Slot numbers are not visible at the ports, so only the ring order is kept.
  class ring_list_scoreboard;
    logic [15:0] entries[$];
    int cursor_pos;
    int capacity;
    out_rsp_t pending[$];
    int fail_count;
    int checked_count;
    int full_refusals;
    int empty_hits;
    int peak_count;

    function new(int cap);
      capacity = cap;
      cursor_pos = 0;
      fail_count = 0;
      checked_count = 0;
      full_refusals = 0;
      empty_hits = 0;
      peak_count = 0;
    endfunction

    task report(string what);
      if (fail_count < 30) $display("MISMATCH at %0t: %s", $realtime, what);
      fail_count++;
    endtask

    function void note_request(in_req_t r);
      out_rsp_t rsp;
      logic [1:0] st;
      int n;
      st = ST_DONE;
      n = entries.size();
      case (r.req_type)
        REQ_INSERT: begin
          if (n >= capacity) begin
            st = ST_FULL;
          end else if (n == 0) begin
            entries.push_back(r.entry_data);
            cursor_pos = 0;
          end else begin
            entries.insert(cursor_pos + 1, r.entry_data);
            cursor_pos++;
          end
        end
        REQ_REMOVE: begin
          if (n == 0) begin
            st = ST_EMPTY;
          end else begin
            entries.delete(cursor_pos);
            // The cursor moves to the following entry; past the last it wraps to the first.
            if (cursor_pos >= entries.size()) cursor_pos = 0;
          end
        end
        REQ_FORWARD: begin
          if (n == 0) st = ST_EMPTY;
          else cursor_pos = (cursor_pos + 1) % n;
        end
        REQ_BACK: begin
          if (n == 0) st = ST_EMPTY;
          else cursor_pos = (cursor_pos + n - 1) % n;
        end
        default: ;  // Read only, and the unused codes behave the same way.
      endcase
      n = entries.size();
      if (st == ST_FULL) full_refusals++;
      if (st == ST_EMPTY) empty_hits++;
      if (n > peak_count) peak_count = n;
      rsp.current_data = (n != 0) ? entries[cursor_pos] : 16'h0000;
      rsp.current_valid = (n != 0);
      rsp.entry_count = n[6:0];
      rsp.status = st;
      pending.push_back(rsp);
    endfunction

    task check_result(out_rsp_t got);
      out_rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result data=%h valid=%b count=%0d status=%0d",
                         got.current_data, got.current_valid, got.entry_count, got.status));
      end else begin
        want = pending.pop_front();
        checked_count++;
        if (got.current_data !== want.current_data || got.current_valid !== want.current_valid
            || got.entry_count !== want.entry_count || got.status !== want.status) begin
          report($sformatf("got data=%h valid=%b count=%0d status=%0d, want %h %b %0d %0d",
                           got.current_data, got.current_valid, got.entry_count, got.status,
                           want.current_data, want.current_valid, want.entry_count,
                           want.status));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_rsp_t out_rsp;

  ring_list_scoreboard sb = new(LIST_CAPACITY);
  int requests_sent = 0;
  int stall_cycles = 0;

  cursor_ring_list_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_rsp);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no request or result for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Presents one request and holds it until the core takes it. Start stays high
  // between back-to-back requests, so it is never lowered and raised in one step.
  task automatic send_request(input in_req_t r, input bit idle_ok);
    if (idle_ok && $urandom_range(99) < 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(r);
    requests_sent++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [15:0] payload);
    in_req_t r;
    r.req_type = op;
    r.entry_data = payload;
    send_request(r, 1'b1);
  endtask

  function automatic in_req_t random_request(input request_mix_t mix);
    in_req_t r;
    int unsigned roll;
    int unsigned ins;
    int unsigned rem;
    case (mix)
      MIX_FILL: begin ins = 60; rem = 10; end
      MIX_DRAIN: begin ins = 10; rem = 60; end
      default: begin ins = 35; rem = 30; end
    endcase
    case ($urandom_range(9))
      0: r.entry_data = 16'h0000;
      1: r.entry_data = 16'hFFFF;
      default: r.entry_data = 16'($urandom);
    endcase
    roll = $urandom_range(99);
    if (roll < ins) r.req_type = REQ_INSERT;
    else if (roll < ins + rem) r.req_type = REQ_REMOVE;
    else if (roll < ins + rem + 12) r.req_type = REQ_FORWARD;
    else if (roll < ins + rem + 24) r.req_type = REQ_BACK;
    else r.req_type = 3'($urandom_range(REQ_READ, 7));
    return r;
  endfunction

  initial begin
    int random_sent;
    int phase;
    int phase_len;
    request_mix_t mix;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Everything on an empty list, including the unused codes.
    send_op(REQ_READ, 16'h0000);
    send_op(REQ_REMOVE, 16'h0000);
    send_op(REQ_FORWARD, 16'h0000);
    send_op(REQ_BACK, 16'h0000);
    send_op(3'd5, 16'hFFFF);
    send_op(3'd6, 16'hFFFF);
    send_op(3'd7, 16'hFFFF);
    // A ring of one: steps land on the same entry, removing it empties the list.
    send_op(REQ_INSERT, 16'h0000);
    send_op(REQ_FORWARD, 16'hFFFF);
    send_op(REQ_BACK, 16'hFFFF);
    send_op(REQ_READ, 16'hFFFF);
    send_op(REQ_REMOVE, 16'h0000);
    send_op(REQ_READ, 16'h0000);
    // Three entries: wrap in both directions and remove at the end of the ring.
    send_op(REQ_INSERT, 16'hFFFF);
    send_op(REQ_INSERT, 16'h1234);
    send_op(REQ_INSERT, 16'h8000);
    send_op(REQ_FORWARD, 16'h0000);
    send_op(REQ_BACK, 16'h0000);
    send_op(REQ_REMOVE, 16'h0000);
    send_op(REQ_REMOVE, 16'h0000);
    send_op(REQ_BACK, 16'h0000);
    send_op(REQ_REMOVE, 16'h0000);
    send_op(REQ_REMOVE, 16'h0000);
    send_op(REQ_BACK, 16'h0000);

    // Phases that fill the store past full, drain it past empty, and mix freely.
    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_REQUESTS) begin
      case (phase % 3)
        0: mix = MIX_FILL;
        1: mix = MIX_MIXED;
        default: mix = MIX_DRAIN;
      endcase
      phase_len = $urandom_range(120, 240);
      for (int k = 0; k < phase_len && random_sent < RANDOM_REQUESTS; k++) begin
        send_request(random_request(mix), !(random_sent >= 900 && random_sent < 1150));
        random_sent++;
      end
      phase++;
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results over %0d fill/mix/drain phases.",
             requests_sent, sb.checked_count, phase);
    $display("Peak of %0d entries, %0d inserts refused as full, %0d requests on an empty list.",
             sb.peak_count, sb.full_refusals, sb.empty_hits);
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
